FILE: rtl/core/bprb_pkg.sv
// ----------------------------------------------------------------------------
// bprb_pkg
// Shared types and codes of the circular byte pipe: actions, internal
// commands, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package bprb_pkg;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 11;

    typedef logic [ACTION_W-1:0]   t_action;
    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // action codes on the input channel
    localparam t_action ACT_WRITE  = 3'd0;
    localparam t_action ACT_READ   = 3'd1;
    localparam t_action ACT_PEEK   = 3'd2;
    localparam t_action ACT_AVAIL  = 3'd3;
    localparam t_action ACT_WCLOSE = 3'd4;
    localparam t_action ACT_RCLOSE = 3'd5;
    localparam t_action ACT_BLOCK  = 3'd6;

    // result status codes
    localparam t_status STS_OK     = 3'd0;
    localparam t_status STS_EOS    = 3'd1;
    localparam t_status STS_NOCONN = 3'd2;
    localparam t_status STS_CLOSED = 3'd3;
    localparam t_status STS_FULL   = 3'd4;
    localparam t_status STS_EMPTY  = 3'd5;

    // configuration register indexes
    localparam t_cfg_idx CFG_PIPE_SIZE = 1'b0;
    localparam t_cfg_idx CFG_CONNECTED = 1'b1;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_PEEK,
        OP_AVAIL,
        OP_WCLOSE,
        OP_RCLOSE,
        OP_BLOCK,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op   op;
        t_byte data_byte;
        t_len  read_len;
    } t_cmd;

    typedef struct packed {
        t_byte   data;
        t_count  count;
        t_status status;
        logic    last;
    } t_res;

endpackage

FILE: rtl/core/bprb_if.sv
// ----------------------------------------------------------------------------
// bprb channel interfaces
// Valid/ready channels for input items, result items and config writes.
// ----------------------------------------------------------------------------
interface bprb_in_if;
    import bprb_pkg::*;
    logic    valid;
    logic    ready;
    t_action action;
    t_byte   data_byte;
    t_len    read_len;

    modport source (output valid, action, data_byte, read_len, input ready);
    modport sink   (input valid, action, data_byte, read_len, output ready);
endinterface

interface bprb_out_if;
    import bprb_pkg::*;
    logic    valid;
    logic    ready;
    t_byte   data;
    t_count  count;
    t_status status;
    logic    last;

    modport source (output valid, data, count, status, last, input ready);
    modport sink   (input valid, data, count, status, last, output ready);
endinterface

interface bprb_cfg_if;
    import bprb_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/core/bprb_ram.sv
// ----------------------------------------------------------------------------
// bprb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bprb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bprb_front.sv
// ----------------------------------------------------------------------------
// bprb_front
// Accepts input items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module bprb_front #(
    parameter int unsigned MAX_BLOCK = 64
) (
    bprb_in_if.sink         i_in,
    output logic            o_push_valid,
    output bprb_pkg::t_cmd  o_push_cmd,
    input  logic            i_push_ready
);
    import bprb_pkg::*;

    t_len w_len_clamped;

    assign w_len_clamped = (i_in.read_len > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK)
                                                               : i_in.read_len;

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;

    always_comb begin
        o_push_cmd.data_byte = i_in.data_byte;
        o_push_cmd.read_len  = LEN_W'(1);
        unique case (i_in.action)
            ACT_WRITE:  o_push_cmd.op = OP_WRITE;
            ACT_READ:   o_push_cmd.op = OP_READ;
            ACT_PEEK:   o_push_cmd.op = OP_PEEK;
            ACT_AVAIL:  o_push_cmd.op = OP_AVAIL;
            ACT_WCLOSE: o_push_cmd.op = OP_WCLOSE;
            ACT_RCLOSE: o_push_cmd.op = OP_RCLOSE;
            ACT_BLOCK: begin
                // zero-length block read answers like an unknown action
                if (i_in.read_len == '0) begin
                    o_push_cmd.op = OP_NOP;
                end else begin
                    o_push_cmd.op       = OP_BLOCK;
                    o_push_cmd.read_len = w_len_clamped;
                end
            end
            default:    o_push_cmd.op = OP_NOP;
        endcase
    end

endmodule

FILE: rtl/core/bprb_queue.sv
// ----------------------------------------------------------------------------
// bprb_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module bprb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  bprb_pkg::t_cmd  i_push_cmd,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output bprb_pkg::t_cmd  o_pop_cmd,
    input  logic            i_pop
);
    import bprb_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/core/bprb_back.sv
// ----------------------------------------------------------------------------
// bprb_back
// Executes commands against the ring: pointers, flags, config registers,
// the ring RAM and the result register.
// ----------------------------------------------------------------------------
module bprb_back #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  bprb_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    bprb_cfg_if.sink        i_cfg,
    bprb_out_if.source      o_out
);
    import bprb_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = (PW + 1 > COUNT_W) ? PW + 1 : COUNT_W;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;

    logic          r_state,     n_state;
    logic [PW-1:0] r_wr_pos,    n_wr_pos;
    logic [PW-1:0] r_rd_pos,    n_rd_pos;
    logic          r_empty,     n_empty;
    logic          r_wclosed,   n_wclosed;
    logic          r_rclosed,   n_rclosed;
    t_cfg_data     r_pipe_size, n_pipe_size;
    logic          r_connected, n_connected;
    t_op           r_op,        n_op;
    t_len          r_left,      n_left;
    logic          r_out_valid, n_out_valid;
    t_res          r_out,       n_out;

    logic [CW-1:0] w_size_ext;
    logic [CW-1:0] w_len_cw;
    logic [PW:0]   w_ring_len;
    logic [PW-1:0] w_wr_addr;
    logic [PW-1:0] w_wr_next;
    logic [PW-1:0] w_rd_next;
    logic          w_now_empty;
    logic          w_last;
    logic [PW:0]   w_avail;
    logic [CW-1:0] w_avail_cw;
    t_status       w_rd_status;
    logic          w_can_load;

    logic          w_ram_we;
    logic          w_ram_re;
    logic [PW-1:0] w_ram_raddr;
    t_byte         w_ram_rdata;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [PW:0]   len);
        logic [PW:0] nx;
        nx = {1'b0, p} + (PW+1)'(1);
        return (nx >= len) ? '0 : nx[PW-1:0];
    endfunction

    // ring length: size register clamped to 1..DEPTH
    assign w_size_ext = CW'(r_pipe_size);
    always_comb begin
        if (w_size_ext == '0) begin
            w_len_cw = CW'(1);
        end else if (w_size_ext > CW'(DEPTH)) begin
            w_len_cw = CW'(DEPTH);
        end else begin
            w_len_cw = w_size_ext;
        end
    end
    assign w_ring_len = w_len_cw[PW:0];

    assign w_wr_addr   = r_empty ? '0 : r_wr_pos;
    assign w_wr_next   = advance(w_wr_addr, w_ring_len);
    assign w_rd_next   = advance(r_rd_pos, w_ring_len);
    assign w_now_empty = (w_rd_next == r_wr_pos);
    assign w_last      = w_now_empty || (r_left == LEN_W'(1));

    always_comb begin
        if (r_empty) begin
            w_avail = '0;
        end else if (r_wr_pos == r_rd_pos) begin
            w_avail = w_ring_len;
        end else if (r_wr_pos > r_rd_pos) begin
            w_avail = {1'b0, r_wr_pos} - {1'b0, r_rd_pos};
        end else begin
            w_avail = {1'b0, r_wr_pos} + w_ring_len - {1'b0, r_rd_pos};
        end
    end
    assign w_avail_cw = CW'(w_avail);

    always_comb begin
        if (!r_connected) begin
            w_rd_status = STS_NOCONN;
        end else if (r_rclosed) begin
            w_rd_status = STS_CLOSED;
        end else if (r_empty) begin
            w_rd_status = r_wclosed ? STS_EOS : STS_EMPTY;
        end else begin
            w_rd_status = STS_OK;
        end
    end

    // result register frees up when empty or taken this cycle
    assign w_can_load = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_wr_pos    = r_wr_pos;
        n_rd_pos    = r_rd_pos;
        n_empty     = r_empty;
        n_wclosed   = r_wclosed;
        n_rclosed   = r_rclosed;
        n_pipe_size = r_pipe_size;
        n_connected = r_connected;
        n_op        = r_op;
        n_left      = r_left;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_ram_raddr = r_rd_pos;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_can_load) begin
                    o_cmd_pop   = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '{data: '0, count: '0, status: STS_OK, last: 1'b1};
                    unique case (i_cmd.op) inside
                        OP_WRITE: begin
                            if (!r_connected) begin
                                n_out.status = STS_NOCONN;
                            end else if (r_wclosed || r_rclosed) begin
                                n_out.status = STS_CLOSED;
                            end else if (!r_empty && (r_wr_pos == r_rd_pos)) begin
                                n_out.status = STS_FULL;
                            end else begin
                                w_ram_we = 1'b1;
                                n_wr_pos = w_wr_next;
                                n_empty  = 1'b0;
                                if (r_empty) begin
                                    n_rd_pos = '0;
                                end
                            end
                        end
                        OP_READ, OP_PEEK, OP_BLOCK: begin
                            if (w_rd_status != STS_OK) begin
                                n_out.status = w_rd_status;
                            end else begin
                                // byte comes back from the ram next cycle
                                n_out_valid = r_out_valid && !o_out.ready;
                                n_out       = r_out;
                                w_ram_re    = 1'b1;
                                n_state     = S_FETCH;
                                n_op        = i_cmd.op;
                                n_left      = i_cmd.read_len;
                            end
                        end
                        OP_AVAIL: begin
                            n_out.count = w_avail_cw[COUNT_W-1:0];
                        end
                        OP_WCLOSE: begin
                            n_wclosed = 1'b1;
                        end
                        OP_RCLOSE: begin
                            n_rclosed = 1'b1;
                            n_empty   = 1'b1;
                        end
                        OP_NOP: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out       = '{data: w_ram_rdata, count: '0, status: STS_OK,
                                   last: 1'b1};
                    if (r_op == OP_PEEK) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_pos   = w_rd_next;
                        n_left     = r_left - LEN_W'(1);
                        n_out.last = w_last;
                        if (w_now_empty) begin
                            n_empty = 1'b1;
                        end
                        if (w_last) begin
                            n_state = S_IDLE;
                        end else begin
                            w_ram_re    = 1'b1;
                            w_ram_raddr = w_rd_next;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PIPE_SIZE: begin
                    n_pipe_size = i_cfg.wdata;
                    n_wr_pos    = '0;
                    n_rd_pos    = '0;
                    n_empty     = 1'b1;
                end
                CFG_CONNECTED: n_connected = i_cfg.wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_left <= n_left;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_empty     <= 1'b1;
            r_wclosed   <= 1'b0;
            r_rclosed   <= 1'b0;
            r_pipe_size <= CFG_DATA_W'(DEPTH);
            r_connected <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_pos    <= n_wr_pos;
            r_rd_pos    <= n_rd_pos;
            r_empty     <= n_empty;
            r_wclosed   <= n_wclosed;
            r_rclosed   <= n_rclosed;
            r_pipe_size <= n_pipe_size;
            r_connected <= n_connected;
            r_out_valid <= n_out_valid;
        end
    end

    bprb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_wr_addr),
        .i_wdata (i_cmd.data_byte),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out.data;
    assign o_out.count  = r_out.count;
    assign o_out.status = r_out.status;
    assign o_out.last   = r_out.last;

endmodule

FILE: rtl/core/byte_pipe_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// byte_pipe_ring_buffer_unit
// Circular byte FIFO with status-coded access actions.
// ----------------------------------------------------------------------------
// The front end classifies each input transfer into a command and pushes it
// into a two-entry queue; the back end pops commands and runs them against
// the ring RAM, which has a registered read. Write, available, close and
// unknown actions sustain one per cycle while results are taken. A read or
// peek that finds data issues the ram read, then loads the result from the
// fetch state. A block read of up to n bytes gives one result transfer per
// byte, the last marked. Failed accesses load a status result without a ram
// read. The result register lets the back end run ahead by one result; a
// stalled result side fills the queue and then stalls the input side. The
// ring has no clearing pass; config writes are accepted every cycle.
module byte_pipe_ring_buffer_unit #(
    parameter int unsigned DEPTH     = 1024,
    parameter int unsigned MAX_BLOCK = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bprb_in_if.sink     i_in,
    bprb_cfg_if.sink    i_cfg,
    bprb_out_if.source  o_out
);
    import bprb_pkg::*;

    logic w_push_valid;
    logic w_push_ready;
    t_cmd w_push_cmd;
    logic w_pop_valid;
    logic w_pop;
    t_cmd w_pop_cmd;

    bprb_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .o_push_cmd   (w_push_cmd),
        .i_push_ready (w_push_ready)
    );

    bprb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_cmd   (w_push_cmd),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_cmd    (w_pop_cmd),
        .i_pop        (w_pop)
    );

    bprb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .i_cmd       (w_pop_cmd),
        .o_cmd_pop   (w_pop),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

endmodule
